FILE: hw/rtl/assert_macros.svh
// Assertion macros for the RTL of this project.
// Define NO_ASSERTIONS to leave every check out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check that a property holds at each rising clock edge outside reset.
`define ASSERT_CHK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_CHK(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif
`endif

FILE: hw/rtl/plob_pkg.sv
// ----------------------------------------------------------------------------
// plob_pkg
// Shared types and constants of the price level order book.
// ----------------------------------------------------------------------------
package plob_pkg;

  localparam int unsigned LEVELS_DEF = 64;
  localparam int unsigned TOPS_DEF   = 5;
  localparam int unsigned PW         = 32;  // price width
  localparam int unsigned QW         = 32;  // quantity width
  localparam int unsigned RW         = 38;  // resting total width
  localparam int unsigned WW         = 20;  // window register width
  localparam int unsigned IW         = 5;   // row index width
  localparam int unsigned SW         = 3;   // status width
  localparam int unsigned EW         = PW + QW;

  typedef enum logic [SW-1:0] {
    ST_INSERTED = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_IGNORED  = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_SUM_RD,
    S_SUM_ACC,
    S_ROW_RD,
    S_ROW_OUT
  } state_e;

endpackage

FILE: hw/rtl/plob_ram.sv
// ----------------------------------------------------------------------------
// plob_ram
// One side's level table: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module plob_ram #(
  parameter int unsigned DEPTH = plob_pkg::LEVELS_DEF,
  parameter int unsigned AW    = $clog2(plob_pkg::LEVELS_DEF),
  parameter int unsigned DW    = plob_pkg::EW
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  // Write and read the table
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/price_level_order_book.sv
// ----------------------------------------------------------------------------
// price_level_order_book
// Bid and ask level tables kept sorted by price, with level updates and
// top-of-book snapshots.
// ----------------------------------------------------------------------------
// Usage: raise start_i with mode/side/price/qty; the item transfers at a
// rising edge where start_i is high and busy_o is low. Each result appears
// for one cycle with result_valid_o high; the receiver cannot stall it.
// An update (mode 0) returns one status result. It scans the side's table
// from the lowest price, with a read and a compare state per level passed,
// then shifts entries for an insert or remove, with a read and a write
// state per moved entry, since each side's table has a single read port.
// A snapshot (mode 1) first walks both tables in parallel from the best
// level while within depth_window (skipped when the window is zero), then
// emits TOPS rows, each read and then output, the last with last_o set.
// The user must write depth_window through cfg_we_i/cfg_wdata_i only while
// busy_o is low; the block itself does not enforce this.
// Reset empties both sides and clears the window; no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module price_level_order_book #(
  parameter int unsigned LEVELS = plob_pkg::LEVELS_DEF,
  parameter int unsigned TOPS   = plob_pkg::TOPS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic                    mode_i,
  input  logic                    side_i,
  input  logic [plob_pkg::PW-1:0] price_i,
  input  logic [plob_pkg::QW-1:0] qty_i,
  input  logic                    cfg_we_i,
  input  logic [plob_pkg::WW-1:0] cfg_wdata_i,
  output logic                    result_valid_o,
  output logic                    kind_o,
  output logic [plob_pkg::SW-1:0] status_o,
  output logic [plob_pkg::IW-1:0] level_index_o,
  output logic [plob_pkg::PW-1:0] bid_price_o,
  output logic [plob_pkg::QW-1:0] bid_qty_o,
  output logic [plob_pkg::PW-1:0] ask_price_o,
  output logic [plob_pkg::QW-1:0] ask_qty_o,
  output logic [plob_pkg::RW-1:0] bid_resting_o,
  output logic [plob_pkg::RW-1:0] ask_resting_o,
  output logic                    last_o
);

  localparam int unsigned AW = $clog2(LEVELS);
  localparam int unsigned CW = $clog2(LEVELS + 1);
  localparam int unsigned KW = (CW > plob_pkg::IW) ? CW : plob_pkg::IW;
  localparam int unsigned PW = plob_pkg::PW;
  localparam int unsigned QW = plob_pkg::QW;
  localparam int unsigned RW = plob_pkg::RW;
  localparam int unsigned EW = plob_pkg::EW;
  localparam logic [CW-1:0] FULL_CNT  = CW'(LEVELS);
  localparam logic [KW-1:0] TOPS_LAST = KW'(TOPS - 1);
  localparam logic [RW-1:0] RMAX      = '1;

  plob_pkg::state_e  state_q, state_d;
  plob_pkg::status_e st_q, st_d;
  logic [KW-1:0] idx_q, idx_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] bcnt_q, bcnt_d, acnt_q, acnt_d;
  logic [plob_pkg::WW-1:0] win_q;
  logic          side_q, side_d;
  logic [PW-1:0] price_q, price_d;
  logic [QW-1:0] qty_q, qty_d;
  logic          ins_q, ins_d;
  logic [RW-1:0] bsum_q, bsum_d, asum_q, asum_d;
  logic [PW-1:0] bbest_q, bbest_d, abest_q, abest_d;
  logic          bact_q, bact_d, aact_q, aact_d;

  logic          vld_q, vld_d;
  logic          kind_q, kind_d, last_q, last_d;
  logic [plob_pkg::SW-1:0] ost_q, ost_d;
  logic [plob_pkg::IW-1:0] oidx_q, oidx_d;
  logic [PW-1:0] obp_q, obp_d, oap_q, oap_d;
  logic [QW-1:0] obq_q, obq_d, oaq_q, oaq_d;
  logic [RW-1:0] obr_q, obr_d, oar_q, oar_d;

  // Table ports
  logic          wr_en;
  logic [AW-1:0] waddr, raddr_upd, b_raddr, a_raddr;
  logic [EW-1:0] wdata, b_rdata, a_rdata, u_rdata;

  logic [CW-1:0] n_cur;
  logic [KW-1:0] b_top;
  logic [PW-1:0] b_p, a_p, u_p, b_bestv, a_bestv;
  logic [QW-1:0] b_qv, a_qv;
  logic [PW-1:0] b_diff, a_diff;
  logic [RW:0]   b_add, a_add;
  logic          b_go, a_go;

  plob_ram #(.DEPTH(LEVELS), .AW(AW), .DW(EW)) u_bid_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en && side_q),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  plob_ram #(.DEPTH(LEVELS), .AW(AW), .DW(EW)) u_ask_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en && !side_q),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  // Select the side under update and the snapshot walk addresses
  assign n_cur   = side_q ? bcnt_q : acnt_q;
  assign u_rdata = side_q ? b_rdata : a_rdata;
  assign u_p     = u_rdata[EW-1:QW];
  assign b_top   = KW'(bcnt_q) - KW'(1) - idx_q;
  assign b_p     = b_rdata[EW-1:QW];
  assign b_qv    = b_rdata[QW-1:0];
  assign a_p     = a_rdata[EW-1:QW];
  assign a_qv    = a_rdata[QW-1:0];
  assign b_bestv = (idx_q == '0) ? b_p : bbest_q;
  assign a_bestv = (idx_q == '0) ? a_p : abest_q;
  assign b_diff  = b_bestv - b_p;
  assign a_diff  = a_p - a_bestv;
  assign b_add   = {1'b0, bsum_q} + (RW + 1)'(b_qv);
  assign a_add   = {1'b0, asum_q} + (RW + 1)'(a_qv);
  assign b_go    = bact_q && (idx_q < KW'(bcnt_q));
  assign a_go    = aact_q && (idx_q < KW'(acnt_q));
  assign b_raddr = (state_q == plob_pkg::S_SUM_RD || state_q == plob_pkg::S_ROW_RD)
                   ? b_top[AW-1:0] : raddr_upd;
  assign a_raddr = (state_q == plob_pkg::S_SUM_RD || state_q == plob_pkg::S_ROW_RD)
                   ? idx_q[AW-1:0] : raddr_upd;

  // Next state, table accesses and result
  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    idx_d   = idx_q;
    pos_d   = pos_q;
    bcnt_d  = bcnt_q;
    acnt_d  = acnt_q;
    side_d  = side_q;
    price_d = price_q;
    qty_d   = qty_q;
    ins_d   = ins_q;
    bsum_d  = bsum_q;
    asum_d  = asum_q;
    bbest_d = bbest_q;
    abest_d = abest_q;
    bact_d  = bact_q;
    aact_d  = aact_q;
    vld_d   = 1'b0;
    kind_d  = kind_q;
    last_d  = last_q;
    ost_d   = ost_q;
    oidx_d  = oidx_q;
    obp_d   = obp_q;
    obq_d   = obq_q;
    oap_d   = oap_q;
    oaq_d   = oaq_q;
    obr_d   = obr_q;
    oar_d   = oar_q;
    wr_en     = 1'b0;
    waddr     = pos_q[AW-1:0];
    wdata     = {price_q, qty_q};
    raddr_upd = idx_q[AW-1:0];

    unique case (state_q)
      plob_pkg::S_IDLE: begin
        if (start_i) begin
          side_d  = side_i;
          price_d = price_i;
          qty_d   = qty_i;
          idx_d   = '0;
          if (mode_i) begin
            bsum_d  = '0;
            asum_d  = '0;
            bact_d  = (win_q != '0);
            aact_d  = (win_q != '0);
            state_d = plob_pkg::S_SUM_RD;
          end else begin
            state_d = plob_pkg::S_SCAN_RD;
          end
        end
      end
      // Scan upward for the first price not below the update price
      plob_pkg::S_SCAN_RD: begin
        if (idx_q == KW'(n_cur)) begin
          pos_d   = idx_q[CW-1:0];
          ins_d   = 1'b0;
          state_d = plob_pkg::S_DECIDE;
        end else begin
          state_d = plob_pkg::S_SCAN_CMP;
        end
      end
      plob_pkg::S_SCAN_CMP: begin
        if (u_p < price_q) begin
          idx_d   = idx_q + KW'(1);
          state_d = plob_pkg::S_SCAN_RD;
        end else begin
          pos_d   = idx_q[CW-1:0];
          ins_d   = (u_p == price_q);  // found flag until decided
          state_d = plob_pkg::S_DECIDE;
        end
      end
      plob_pkg::S_DECIDE: begin
        priority if (ins_q && qty_q == '0) begin
          // Remove: pull the entries above down by one
          st_d  = plob_pkg::ST_REMOVED;
          ins_d = 1'b0;
          idx_d = KW'(pos_q);
          if (side_q) bcnt_d = bcnt_q - CW'(1);
          else        acnt_d = acnt_q - CW'(1);
          state_d = plob_pkg::S_SHIFT_RD;
        end else if (ins_q) begin
          wr_en   = 1'b1;
          st_d    = plob_pkg::ST_UPDATED;
          vld_d   = 1'b1;
          state_d = plob_pkg::S_IDLE;
        end else if (qty_q == '0 || n_cur == FULL_CNT) begin
          st_d    = (qty_q == '0) ? plob_pkg::ST_IGNORED : plob_pkg::ST_FULL;
          vld_d   = 1'b1;
          state_d = plob_pkg::S_IDLE;
        end else begin
          // Insert: push the entries from the top down one place up
          st_d  = plob_pkg::ST_INSERTED;
          ins_d = 1'b1;
          idx_d = KW'(n_cur);
          if (side_q) bcnt_d = bcnt_q + CW'(1);
          else        acnt_d = acnt_q + CW'(1);
          state_d = plob_pkg::S_SHIFT_RD;
        end
        kind_d = 1'b0;
        last_d = 1'b1;
        ost_d  = st_d;
        oidx_d = '0;
        obp_d  = '0;
        obq_d  = '0;
        oap_d  = '0;
        oaq_d  = '0;
        obr_d  = '0;
        oar_d  = '0;
      end
      plob_pkg::S_SHIFT_RD: begin
        if (ins_q) begin
          if (idx_q > KW'(pos_q)) begin
            raddr_upd = AW'(idx_q - KW'(1));
            state_d   = plob_pkg::S_SHIFT_WR;
          end else begin
            wr_en   = 1'b1;
            vld_d   = 1'b1;
            state_d = plob_pkg::S_IDLE;
          end
        end else begin
          if (idx_q < KW'(n_cur)) begin
            raddr_upd = AW'(idx_q + KW'(1));
            state_d   = plob_pkg::S_SHIFT_WR;
          end else begin
            vld_d   = 1'b1;
            state_d = plob_pkg::S_IDLE;
          end
        end
      end
      plob_pkg::S_SHIFT_WR: begin
        wr_en   = 1'b1;
        waddr   = idx_q[AW-1:0];
        wdata   = u_rdata;
        idx_d   = ins_q ? idx_q - KW'(1) : idx_q + KW'(1);
        state_d = plob_pkg::S_SHIFT_RD;
      end
      // Walk both sides outward from the best level
      plob_pkg::S_SUM_RD: begin
        bact_d = b_go;
        aact_d = a_go;
        if (!b_go && !a_go) begin
          idx_d   = '0;
          state_d = plob_pkg::S_ROW_RD;
        end else begin
          state_d = plob_pkg::S_SUM_ACC;
        end
      end
      plob_pkg::S_SUM_ACC: begin
        if (bact_q) begin
          bbest_d = b_bestv;
          if (b_diff > PW'(win_q)) bact_d = 1'b0;
          else bsum_d = b_add[RW] ? RMAX : b_add[RW-1:0];
        end
        if (aact_q) begin
          abest_d = a_bestv;
          if (a_diff > PW'(win_q)) aact_d = 1'b0;
          else asum_d = a_add[RW] ? RMAX : a_add[RW-1:0];
        end
        idx_d   = idx_q + KW'(1);
        state_d = plob_pkg::S_SUM_RD;
      end
      plob_pkg::S_ROW_RD: begin
        state_d = plob_pkg::S_ROW_OUT;
      end
      // Emit one snapshot row
      plob_pkg::S_ROW_OUT: begin
        vld_d  = 1'b1;
        kind_d = 1'b1;
        ost_d  = '0;
        oidx_d = idx_q[plob_pkg::IW-1:0];
        obp_d  = (idx_q < KW'(bcnt_q)) ? b_p : '0;
        obq_d  = (idx_q < KW'(bcnt_q)) ? b_qv : '0;
        oap_d  = (idx_q < KW'(acnt_q)) ? a_p : '0;
        oaq_d  = (idx_q < KW'(acnt_q)) ? a_qv : '0;
        obr_d  = bsum_q;
        oar_d  = asum_q;
        last_d = (idx_q == TOPS_LAST);
        idx_d  = idx_q + KW'(1);
        state_d = (idx_q == TOPS_LAST) ? plob_pkg::S_IDLE : plob_pkg::S_ROW_RD;
      end
      default: state_d = plob_pkg::S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= plob_pkg::S_IDLE;
      bcnt_q  <= '0;
      acnt_q  <= '0;
      win_q   <= '0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      bcnt_q  <= bcnt_d;
      acnt_q  <= acnt_d;
      vld_q   <= vld_d;
      if (cfg_we_i) win_q <= cfg_wdata_i;
    end
  end

  // Working and result payload
  always_ff @(posedge clk_i) begin
    st_q    <= st_d;
    idx_q   <= idx_d;
    pos_q   <= pos_d;
    side_q  <= side_d;
    price_q <= price_d;
    qty_q   <= qty_d;
    ins_q   <= ins_d;
    bsum_q  <= bsum_d;
    asum_q  <= asum_d;
    bbest_q <= bbest_d;
    abest_q <= abest_d;
    bact_q  <= bact_d;
    aact_q  <= aact_d;
    kind_q  <= kind_d;
    last_q  <= last_d;
    ost_q   <= ost_d;
    oidx_q  <= oidx_d;
    obp_q   <= obp_d;
    obq_q   <= obq_d;
    oap_q   <= oap_d;
    oaq_q   <= oaq_d;
    obr_q   <= obr_d;
    oar_q   <= oar_d;
  end

  assign busy_o         = (state_q != plob_pkg::S_IDLE);
  assign result_valid_o = vld_q;
  assign kind_o         = kind_q;
  assign status_o       = ost_q;
  assign level_index_o  = oidx_q;
  assign bid_price_o    = obp_q;
  assign bid_qty_o      = obq_q;
  assign ask_price_o    = oap_q;
  assign ask_qty_o      = oaq_q;
  assign bid_resting_o  = obr_q;
  assign ask_resting_o  = oar_q;
  assign last_o         = last_q;

  `ASSERT_NEVER(a_bid_cnt, bcnt_q > FULL_CNT, "bid level count above capacity")
  `ASSERT_NEVER(a_ask_cnt, acnt_q > FULL_CNT, "ask level count above capacity")
  `ASSERT_CHK(a_vld_busy, vld_q |-> $past(state_q != plob_pkg::S_IDLE), "result without work")
  `ASSERT_CHK(a_upd_last, (vld_q && !kind_q) |-> last_q, "update status not marked last")

endmodule

FILE: bench/tb_price_level_order_book.sv
// ----------------------------------------------------------------------------
// tb_price_level_order_book
// Self-checking bench for the price level order book. A behavioral book model
// in the scoreboard predicts update statuses and snapshot rows; every result
// strobe is compared field by field. Stimulus mixes directed corner cases,
// random updates on a narrow price range to fill and drain the sides, and
// snapshots under several window settings.
// ----------------------------------------------------------------------------
module tb_price_level_order_book;

  localparam int unsigned LEVELS = plob_pkg::LEVELS_DEF;
  localparam int unsigned TOPS   = plob_pkg::TOPS_DEF;
  localparam int unsigned PW     = plob_pkg::PW;
  localparam int unsigned QW     = plob_pkg::QW;
  localparam int unsigned RW     = plob_pkg::RW;
  localparam int unsigned WW     = plob_pkg::WW;
  localparam int unsigned IW     = plob_pkg::IW;
  localparam int unsigned SW     = plob_pkg::SW;
  localparam int unsigned WDOG   = 20000;

  typedef struct packed {
    logic          kind;
    logic [SW-1:0] status;
    logic [IW-1:0] level_index;
    logic [PW-1:0] bid_price;
    logic [QW-1:0] bid_qty;
    logic [PW-1:0] ask_price;
    logic [QW-1:0] ask_qty;
    logic [RW-1:0] bid_resting;
    logic [RW-1:0] ask_resting;
    logic          last;
  } book_row_t;

  // Book model and queue of pending results
  class book_scoreboard;
    logic [PW-1:0] prices[2][$];
    logic [QW-1:0] qtys[2][$];
    logic [WW-1:0] window;
    book_row_t     pending[$];
    int            mismatches;

    function new();
      window = '0;
      mismatches = 0;
    endfunction

    function plob_pkg::status_e apply(int s, logic [PW-1:0] price, logic [QW-1:0] qty);
      int pos;
      pos = 0;
      while (pos < prices[s].size() && prices[s][pos] < price) pos++;
      if (pos < prices[s].size() && prices[s][pos] == price) begin
        if (qty == 0) begin
          prices[s].delete(pos);
          qtys[s].delete(pos);
          return plob_pkg::ST_REMOVED;
        end
        qtys[s][pos] = qty;
        return plob_pkg::ST_UPDATED;
      end
      if (qty == 0) return plob_pkg::ST_IGNORED;
      if (prices[s].size() >= LEVELS) return plob_pkg::ST_FULL;
      prices[s].insert(pos, price);
      qtys[s].insert(pos, qty);
      return plob_pkg::ST_INSERTED;
    endfunction

    function logic [RW-1:0] window_total(int s);
      logic [63:0]   sum;
      logic [PW-1:0] best, diff;
      int            n, idx;
      sum = 0;
      n = prices[s].size();
      if (window == 0 || n == 0) return '0;
      best = (s == 1) ? prices[s][n-1] : prices[s][0];
      for (int k = 0; k < n; k++) begin
        idx = (s == 1) ? n - 1 - k : k;
        diff = (s == 1) ? best - prices[s][idx] : prices[s][idx] - best;
        if (diff > window) break;
        sum += qtys[s][idx];
        if (sum > 64'h3F_FFFF_FFFF) sum = 64'h3F_FFFF_FFFF;
      end
      return sum[RW-1:0];
    endfunction

    // Note an accepted item and queue what it must produce
    function void note_item(logic mode, logic side, logic [PW-1:0] price,
                            logic [QW-1:0] qty);
      book_row_t     r;
      logic [RW-1:0] br, ar;
      int            nb, na;
      if (!mode) begin
        r = '0;
        r.status = apply(side ? 1 : 0, price, qty);
        r.last = 1'b1;
        pending.push_back(r);
        return;
      end
      br = window_total(1);
      ar = window_total(0);
      nb = prices[1].size();
      na = prices[0].size();
      for (int k = 0; k < TOPS; k++) begin
        r = '0;
        r.kind = 1'b1;
        r.level_index = IW'(k);
        if (k < nb) begin
          r.bid_price = prices[1][nb-1-k];
          r.bid_qty = qtys[1][nb-1-k];
        end
        if (k < na) begin
          r.ask_price = prices[0][k];
          r.ask_qty = qtys[0][k];
        end
        r.bid_resting = br;
        r.ask_resting = ar;
        r.last = (k == TOPS - 1);
        pending.push_back(r);
      end
    endfunction

    // Compare one result against the oldest expectation
    function void check_row(book_row_t act);
      book_row_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %h", act);
        return;
      end
      exp_r = pending.pop_front();
      if (act !== exp_r) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result mismatch\n  exp %h\n  got %h", exp_r, act);
      end
    endfunction
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start_i = 1'b0;
  logic          busy_o;
  logic          mode_i = 1'b0;
  logic          side_i = 1'b0;
  logic [PW-1:0] price_i = '0;
  logic [QW-1:0] qty_i = '0;
  logic          cfg_we_i = 1'b0;
  logic [WW-1:0] cfg_wdata_i = '0;
  logic          result_valid_o, kind_o, last_o;
  logic [SW-1:0] status_o;
  logic [IW-1:0] level_index_o;
  logic [PW-1:0] bid_price_o, ask_price_o;
  logic [QW-1:0] bid_qty_o, ask_qty_o;
  logic [RW-1:0] bid_resting_o, ask_resting_o;

  book_scoreboard sb = new();
  int             idle_cycles = 0;

  price_level_order_book u_top (.*);

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Check results and count cycles without a transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o)
        sb.check_row({kind_o, status_o, level_index_o, bid_price_o, bid_qty_o,
                      ask_price_o, ask_qty_o, bid_resting_o, ask_resting_o,
                      last_o});
      if (result_valid_o || (start_i && !busy_o)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    if (idle_cycles > WDOG) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic random_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 2);
    repeat (n) @(posedge clk_i);
  endtask

  // Present one item and hold it until it transfers; start stays high after
  // the transfer until the next item or an idle phase lowers it
  task automatic send_item(logic mode, logic side, logic [PW-1:0] price,
                           logic [QW-1:0] qty);
    if ($urandom_range(0, 2) == 0) begin
      start_i <= 1'b0;
      random_gap();
    end
    start_i <= 1'b1;
    mode_i <= mode;
    side_i <= side;
    price_i <= price;
    qty_i <= qty;
    do @(posedge clk_i); while (busy_o);
    sb.note_item(mode, side, price, qty);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_window(logic [WW-1:0] w);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.window = w;
  endtask

  task automatic random_phase(int count, int span);
    logic [PW-1:0] base;
    base = $urandom_range(0, 1) ? 32'd1000 : 32'hFFFF_FF00;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 7) == 0)
        send_item(1'b1, 1'($urandom), $urandom, $urandom);
      else if ($urandom_range(0, 19) == 0)
        send_item(1'b0, 1'($urandom), $urandom, $urandom);
      else
        send_item(1'b0, 1'($urandom), base + $urandom_range(0, span),
                  ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty snapshot, extremes, ignore, update, remove
    send_item(1'b1, 1'b1, '1, '1);
    send_item(1'b0, 1'b1, 32'd0, '1);
    send_item(1'b0, 1'b1, '1, 32'd1);
    send_item(1'b0, 1'b0, '1, '1);
    send_item(1'b0, 1'b0, 32'd0, 32'd7);
    send_item(1'b0, 1'b0, 32'd55, 32'd0);
    send_item(1'b0, 1'b1, '1, 32'd9);
    send_item(1'b1, 1'b0, 32'd0, 32'd0);
    write_window('1);
    send_item(1'b1, 1'b0, 32'd0, 32'd0);
    send_item(1'b0, 1'b1, 32'd0, 32'd0);
    send_item(1'b0, 1'b0, '1, 32'd0);
    send_item(1'b1, 1'b0, 32'd0, 32'd0);

    // Fill the bid side to full, try an insert and an update on it, take a snapshot, then remove every level
    write_window(20'd3);
    for (int i = 0; i < LEVELS; i++) send_item(1'b0, 1'b1, 32'd100 + 2 * i, $urandom);
    send_item(1'b0, 1'b1, 32'd1, 32'd5);
    send_item(1'b0, 1'b1, 32'd100, 32'd6);
    send_item(1'b1, 1'b0, 32'd0, 32'd0);
    for (int i = 0; i < LEVELS; i++) send_item(1'b0, 1'b1, 32'd100 + 2 * i, 32'd0);

    // Random phases under several windows
    write_window(20'd0);
    random_phase(60, 40);
    write_window(20'd1);
    random_phase(60, 40);
    write_window(20'd10);
    random_phase(60, 100);
    write_window(WW'($urandom));
    random_phase(50, 20);
    write_window('1);
    random_phase(50, 200);
    send_item(1'b1, 1'b0, 32'd0, 32'd0);

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/plob_pkg.sv
hw/rtl/plob_ram.sv
hw/rtl/price_level_order_book.sv
bench/tb_price_level_order_book.sv
